// ----- src/kmeans_assign_update_unit_defines.svh -----
// Assertion macros shared by the k-means unit RTL.
// Included by the modules that carry concurrent checks.
`ifndef KMEANS_ASSIGN_UPDATE_UNIT_DEFINES_SVH
`define KMEANS_ASSIGN_UPDATE_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define KMAU_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("kmau check failed");
`define KMAU_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("kmau check failed");
`else
`define KMAU_ASSERT(lbl, clk, rst, prop)
`define KMAU_ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`endif
`endif

// ----- src/kmau_pkg.sv -----
// Shared types, codes and constants for the k-means assign/update unit.
// No dependencies.
package kmau_pkg;
   localparam int DEF_MAX_CENTERS = 16;
   localparam int DEF_MAX_DIMS    = 128;
   localparam int DEF_COUNT_BITS  = 24;

   localparam int ELEM_BITS  = 16;
   localparam int SUM_BITS   = 40;
   localparam int TOTAL_BITS = 48;
   localparam int ROOT_BITS  = 20;
   localparam int QUOT_BITS  = 16;

   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 8;
   localparam logic [CSR_IDX_BITS-1:0] CSR_CENTERS = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_DIMS    = 2'd1;
   localparam logic [4:0] RST_CENTERS = 5'd10;
   localparam logic [7:0] RST_DIMS    = 8'd100;

   localparam logic [1:0] CMD_LOAD   = 2'd0;
   localparam logic [1:0] CMD_SAMPLE = 2'd1;
   localparam logic [1:0] CMD_FINISH = 2'd2;

   localparam logic KIND_ASSIGN = 1'b0;
   localparam logic KIND_TOTAL  = 1'b1;

   typedef enum logic [1:0] {OP_LOAD, OP_SAMPLE, OP_FINISH} op_type;

   typedef struct packed {
      op_type      op;
      logic        last;
      logic [3:0]  center_slot;
      logic [6:0]  dim_slot;
      logic [15:0] elem_value;
   } work_type;
endpackage

// ----- src/kmau_if.sv -----
// Channel interfaces of the k-means unit: request, response, register write.
// Plain valid/ready channels; no package dependency.
interface kmau_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  command;
   logic [3:0]  center_slot;
   logic [6:0]  dim_slot;
   logic [15:0] elem_value;
   modport source (output valid, command, center_slot, dim_slot, elem_value, input ready);
   modport sink (input valid, command, center_slot, dim_slot, elem_value, output ready);
endinterface

interface kmau_rsp_if;
   logic        valid;
   logic        ready;
   logic        result_kind;
   logic [3:0]  nearest_class;
   logic [19:0] root_distance;
   logic [47:0] total_distance;
   modport source (output valid, result_kind, nearest_class, root_distance, total_distance,
                   input ready);
   modport sink (input valid, result_kind, nearest_class, root_distance, total_distance,
                 output ready);
endinterface

interface kmau_csr_if;
   logic       valid;
   logic       ready;
   logic [1:0] index;
   logic [7:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ----- src/kmau_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module kmau_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end
endmodule

// ----- src/kmau_front.sv -----
// Front end: register file, command decode and a two-entry work queue.
// Depends on kmau_pkg, kmau_if and the assertion macro header.
`include "kmeans_assign_update_unit_defines.svh"
module kmau_front #(
   parameter int MAX_CENTERS = kmau_pkg::DEF_MAX_CENTERS,
   parameter int MAX_DIMS = kmau_pkg::DEF_MAX_DIMS,
   localparam int NCW = $clog2(MAX_CENTERS + 1),
   localparam int NDW = $clog2(MAX_DIMS + 1)
) (
   input  logic               clock,
   input  logic               reset,
   kmau_req_if.sink           req,
   kmau_csr_if.sink           csr,
   input  logic               clearing,
   output logic [NCW-1:0]     n_centers,
   output logic [NDW-1:0]     n_dims,
   output kmau_pkg::work_type q_head,
   output logic               q_valid,
   input  logic               q_pop
);
   import kmau_pkg::*;

   logic [4:0] centers_ff;
   logic [7:0] dims_ff;
   work_type   entry_in;
   logic       keep;
   logic       push;
   work_type   slot_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff;

   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         centers_ff <= RST_CENTERS;
         dims_ff    <= RST_DIMS;
      end else if (csr.valid && csr.ready) begin
         case (csr.index)
            CSR_CENTERS: centers_ff <= csr.data[4:0];
            CSR_DIMS:    dims_ff <= csr.data;
            default: ;
         endcase
      end
   end

   // zero reads as one, anything past the maximum as the maximum
   always_comb begin
      if (centers_ff == '0) begin
         n_centers = NCW'(1);
      end else if (int'(centers_ff) > MAX_CENTERS) begin
         n_centers = NCW'(MAX_CENTERS);
      end else begin
         n_centers = NCW'(centers_ff);
      end
      if (dims_ff == '0) begin
         n_dims = NDW'(1);
      end else if (int'(dims_ff) > MAX_DIMS) begin
         n_dims = NDW'(MAX_DIMS);
      end else begin
         n_dims = NDW'(dims_ff);
      end
   end

   always_comb begin
      entry_in.op          = OP_LOAD;
      entry_in.last        = (int'(req.dim_slot) == int'(n_dims) - 1);
      entry_in.center_slot = req.center_slot;
      entry_in.dim_slot    = req.dim_slot;
      entry_in.elem_value  = req.elem_value;
      keep                 = 1'b0;
      unique case (req.command)
         CMD_LOAD: begin
            keep = (int'(req.center_slot) < MAX_CENTERS) && (int'(req.dim_slot) < MAX_DIMS);
         end
         CMD_SAMPLE: begin
            entry_in.op = OP_SAMPLE;
            keep        = int'(req.dim_slot) < MAX_DIMS;
         end
         CMD_FINISH: begin
            entry_in.op = OP_FINISH;
            keep        = 1'b1;
         end
         default: keep = 1'b0;
      endcase
   end

   // dropped commands are still accepted, just never queued
   assign req.ready = (count_ff != 2'd2) && !clearing;
   assign push      = req.valid && req.ready && keep;
   assign q_valid   = count_ff != 2'd0;
   assign q_head    = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (q_pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         count_ff <= count_ff + 2'(push) - 2'(q_pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= entry_in;
      end
   end

   `KMAU_ASSERT_IMPLY(a_pop_nonempty, clock, reset, q_pop, q_valid)
   `KMAU_ASSERT(a_count_bound, clock, reset, count_ff <= 2'd2)
   `KMAU_ASSERT(a_push_visible, clock, reset, push |=> q_valid)
endmodule

// ----- src/kmau_back.sv -----
// Back end: sequencer for distance search, square root, class update and
// the finish sweep; holds the four memories and the result register.
// Depends on kmau_pkg, kmau_if, kmau_ram and the assertion macro header.
`include "kmeans_assign_update_unit_defines.svh"
module kmau_back #(
   parameter int MAX_CENTERS = kmau_pkg::DEF_MAX_CENTERS,
   parameter int MAX_DIMS = kmau_pkg::DEF_MAX_DIMS,
   parameter int COUNT_BITS = kmau_pkg::DEF_COUNT_BITS,
   localparam int NCW = $clog2(MAX_CENTERS + 1),
   localparam int NDW = $clog2(MAX_DIMS + 1)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [NCW-1:0]     n_centers,
   input  logic [NDW-1:0]     n_dims,
   input  kmau_pkg::work_type q_head,
   input  logic               q_valid,
   output logic               q_pop,
   output logic               clearing,
   kmau_rsp_if.source         rsp
);
   import kmau_pkg::*;

   localparam int ENTRIES   = MAX_CENTERS * MAX_DIMS;
   localparam int CAW       = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int VAW       = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
   localparam int KAW       = $clog2(MAX_CENTERS);
   localparam int DB0       = 2 * ELEM_BITS + $clog2(MAX_DIMS);
   localparam int DIST_BITS = DB0 + (DB0 % 2);
   localparam int RB        = DIST_BITS / 2;
   localparam int RXW       = (RB > ROOT_BITS) ? RB : ROOT_BITS;
   localparam int DVW       = (COUNT_BITS + QUOT_BITS > SUM_BITS) ?
                              (COUNT_BITS + QUOT_BITS) : SUM_BITS;
   localparam int STEPS_MAX = (RB > QUOT_BITS) ? RB : QUOT_BITS;
   localparam int SW        = $clog2(STEPS_MAX + 1);
   localparam logic [ROOT_BITS-1:0] ROOT_MAX = '1;

   typedef enum logic [4:0] {
      S_CLEAR, S_IDLE, S_DIST, S_DRAIN, S_SQRT_LD, S_SQRT, S_EMIT_A, S_CNT_RD,
      S_CNT_WR, S_SUM, S_SUM_DRAIN, S_FIN_CRD, S_FIN_CWT, S_FIN_SRD, S_FIN_SWT,
      S_FIN_DIV, S_FIN_WR, S_FIN_EMIT
   } state_type;

   state_type state_ff;
   logic [NCW-1:0] c_ff;
   logic [NDW-1:0] d_ff;
   logic [CAW-1:0] a_ff;
   logic [CAW-1:0] row_ff;
   logic [SW-1:0]  step_ff;
   logic [TOTAL_BITS-1:0] total_ff;
   logic           rsp_valid_ff;

   // distance pipeline: p1 = read issued, p2 = square registered
   logic           p1_valid_ff, p1_first_ff, p1_last_ff, p1_end_ff;
   logic [NCW-1:0] p1_c_ff;
   logic           p2_valid_ff, p2_first_ff, p2_last_ff, p2_end_ff;
   logic [NCW-1:0] p2_c_ff;
   // class sum update pipeline
   logic           s_valid_ff, s_last_ff;
   logic [CAW-1:0] s_addr_ff;

   logic [2*ELEM_BITS-1:0] sq_ff;
   logic [DIST_BITS-1:0]   acc_ff;
   logic [DIST_BITS-1:0]   best_dist_ff;
   logic [KAW-1:0]         best_ff;
   logic [CAW-1:0]         base_ff;
   logic [DIST_BITS-1:0]   x_ff;
   logic [RB+2:0]          rem_ff;
   logic [RB-1:0]          root_ff;
   logic [COUNT_BITS-1:0]  cnt_ff;
   logic                   active_ff;
   logic                   wr_center_ff;
   logic [DVW-1:0]         div_rem_ff;
   logic [DVW-1:0]         div_dv_ff;
   logic [QUOT_BITS-1:0]   quot_ff;
   logic                   rsp_kind_ff;
   logic [3:0]             rsp_class_ff;
   logic [ROOT_BITS-1:0]   rsp_root_ff;
   logic [TOTAL_BITS-1:0]  rsp_total_ff;

   logic                  cen_we;
   logic [CAW-1:0]        cen_waddr;
   logic [ELEM_BITS-1:0]  cen_wdata, cen_rdata;
   logic                  vb_we;
   logic [VAW-1:0]        vb_waddr, vb_raddr;
   logic [ELEM_BITS-1:0]  vb_rdata;
   logic                  sum_we;
   logic [CAW-1:0]        sum_waddr;
   logic [SUM_BITS-1:0]   sum_wdata, sum_rdata;
   logic                  cnt_we;
   logic [KAW-1:0]        cnt_waddr, cnt_raddr;
   logic [COUNT_BITS-1:0] cnt_wdata, cnt_rdata;

   logic [ELEM_BITS-1:0]   diff;
   logic [2*ELEM_BITS-1:0] sq_c;
   logic [DIST_BITS-1:0]   acc_sum;
   logic [RB+2:0]          rem_sh;
   logic [RB+2:0]          trial;
   logic [RXW-1:0]         root_x;
   logic [ROOT_BITS-1:0]   root_sat;
   logic [TOTAL_BITS:0]    total_sum;
   logic [SUM_BITS:0]      sum_add;
   logic                   out_free;
   logic                   div_sat;

   kmau_ram #(.WIDTH(ELEM_BITS), .DEPTH(ENTRIES)) u_centers (
      .clock(clock), .we(cen_we), .waddr(cen_waddr), .wdata(cen_wdata),
      .raddr(a_ff), .rdata(cen_rdata));
   kmau_ram #(.WIDTH(ELEM_BITS), .DEPTH(MAX_DIMS)) u_vector (
      .clock(clock), .we(vb_we), .waddr(vb_waddr), .wdata(q_head.elem_value),
      .raddr(vb_raddr), .rdata(vb_rdata));
   kmau_ram #(.WIDTH(SUM_BITS), .DEPTH(ENTRIES)) u_sums (
      .clock(clock), .we(sum_we), .waddr(sum_waddr), .wdata(sum_wdata),
      .raddr(a_ff), .rdata(sum_rdata));
   kmau_ram #(.WIDTH(COUNT_BITS), .DEPTH(MAX_CENTERS)) u_counts (
      .clock(clock), .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
      .raddr(cnt_raddr), .rdata(cnt_rdata));

   assign vb_raddr = d_ff[VAW-1:0];
   assign vb_waddr = VAW'(q_head.dim_slot);
   assign clearing = state_ff == S_CLEAR;
   assign out_free = !rsp_valid_ff || rsp.ready;
   assign q_pop    = (state_ff == S_IDLE) && q_valid;

   assign diff    = (vb_rdata > cen_rdata) ? (vb_rdata - cen_rdata) : (cen_rdata - vb_rdata);
   assign sq_c    = {{ELEM_BITS{1'b0}}, diff} * {{ELEM_BITS{1'b0}}, diff};
   assign acc_sum = (p2_first_ff ? '0 : acc_ff) + DIST_BITS'(sq_ff);

   assign rem_sh   = {rem_ff[RB:0], x_ff[DIST_BITS-1 -: 2]};
   assign trial    = (RB + 3)'({root_ff, 2'b01});
   assign root_x   = RXW'(root_ff);
   assign root_sat = (root_x > RXW'(ROOT_MAX)) ? ROOT_MAX : ROOT_BITS'(root_x);
   assign total_sum = {1'b0, total_ff} + (TOTAL_BITS + 1)'(root_sat);
   assign sum_add  = {1'b0, sum_rdata} + (SUM_BITS + 1)'(vb_rdata);
   assign div_sat  = DVW'(sum_rdata) >= (DVW'(cnt_ff) << QUOT_BITS);

   always_comb begin
      cen_we    = 1'b0;
      cen_waddr = CAW'(int'(q_head.center_slot) * MAX_DIMS + int'(q_head.dim_slot));
      cen_wdata = q_head.elem_value;
      vb_we     = 1'b0;
      sum_we    = 1'b0;
      sum_waddr = a_ff;
      sum_wdata = '0;
      cnt_we    = 1'b0;
      cnt_waddr = c_ff[KAW-1:0];
      cnt_wdata = '0;
      cnt_raddr = c_ff[KAW-1:0];
      case (state_ff)
         S_CLEAR: begin
            sum_we    = 1'b1;
            cnt_we    = int'(a_ff) < MAX_CENTERS;
            cnt_waddr = a_ff[KAW-1:0];
         end
         S_IDLE: begin
            cen_we = q_valid && (q_head.op == OP_LOAD);
            vb_we  = q_valid && (q_head.op == OP_SAMPLE);
         end
         S_CNT_RD: cnt_raddr = best_ff;
         S_CNT_WR: begin
            cnt_we    = 1'b1;
            cnt_waddr = best_ff;
            cnt_wdata = (&cnt_rdata) ? cnt_rdata : cnt_rdata + 1'b1;
         end
         S_SUM, S_SUM_DRAIN: begin
            sum_we    = s_valid_ff;
            sum_waddr = s_addr_ff;
            sum_wdata = sum_add[SUM_BITS] ? '1 : sum_add[SUM_BITS-1:0];
         end
         S_FIN_CWT: cnt_we = 1'b1;
         S_FIN_WR: begin
            sum_we    = 1'b1;
            cen_we    = wr_center_ff;
            cen_waddr = a_ff;
            cen_wdata = quot_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         c_ff         <= '0;
         d_ff         <= '0;
         a_ff         <= '0;
         row_ff       <= '0;
         step_ff      <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         p1_valid_ff  <= 1'b0;
         p2_valid_ff  <= 1'b0;
         s_valid_ff   <= 1'b0;
      end else begin
         p1_valid_ff <= 1'b0;
         s_valid_ff  <= 1'b0;
         p2_valid_ff <= p1_valid_ff;
         if (rsp_valid_ff && rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_CLEAR: begin
               a_ff <= a_ff + 1'b1;
               if (int'(a_ff) == ENTRIES - 1) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               c_ff   <= '0;
               d_ff   <= '0;
               a_ff   <= '0;
               row_ff <= '0;
               if (q_valid) begin
                  if (q_head.op == OP_SAMPLE && q_head.last) begin
                     state_ff <= S_DIST;
                  end else if (q_head.op == OP_FINISH) begin
                     state_ff <= S_FIN_CRD;
                  end
               end
            end
            S_DIST: begin
               p1_valid_ff <= 1'b1;
               if (d_ff == n_dims - 1'b1) begin
                  d_ff   <= '0;
                  row_ff <= row_ff + CAW'(MAX_DIMS);
                  a_ff   <= row_ff + CAW'(MAX_DIMS);
                  c_ff   <= c_ff + 1'b1;
                  if (c_ff == n_centers - 1'b1) begin
                     state_ff <= S_DRAIN;
                  end
               end else begin
                  d_ff <= d_ff + 1'b1;
                  a_ff <= a_ff + 1'b1;
               end
            end
            S_DRAIN: begin
               if (p2_valid_ff && p2_end_ff) begin
                  state_ff <= S_SQRT_LD;
               end
            end
            S_SQRT_LD: begin
               step_ff  <= SW'(RB);
               state_ff <= S_SQRT;
            end
            S_SQRT: begin
               step_ff <= step_ff - 1'b1;
               if (step_ff == SW'(1)) begin
                  state_ff <= S_EMIT_A;
               end
            end
            S_EMIT_A: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  total_ff     <= total_sum[TOTAL_BITS] ? '1 : total_sum[TOTAL_BITS-1:0];
                  state_ff     <= S_CNT_RD;
               end
            end
            S_CNT_RD: begin
               d_ff     <= '0;
               state_ff <= S_CNT_WR;
            end
            S_CNT_WR: begin
               a_ff     <= base_ff;
               state_ff <= S_SUM;
            end
            S_SUM: begin
               s_valid_ff <= 1'b1;
               if (d_ff == n_dims - 1'b1) begin
                  state_ff <= S_SUM_DRAIN;
               end else begin
                  d_ff <= d_ff + 1'b1;
                  a_ff <= a_ff + 1'b1;
               end
            end
            S_SUM_DRAIN: begin
               if (s_valid_ff && s_last_ff) begin
                  state_ff <= S_IDLE;
               end
            end
            S_FIN_CRD: begin
               d_ff     <= '0;
               state_ff <= S_FIN_CWT;
            end
            S_FIN_CWT: state_ff <= S_FIN_SRD;
            S_FIN_SRD: state_ff <= S_FIN_SWT;
            S_FIN_SWT: begin
               step_ff <= SW'(QUOT_BITS);
               if (active_ff && (d_ff < n_dims) && !div_sat) begin
                  state_ff <= S_FIN_DIV;
               end else begin
                  state_ff <= S_FIN_WR;
               end
            end
            S_FIN_DIV: begin
               step_ff <= step_ff - 1'b1;
               if (step_ff == SW'(1)) begin
                  state_ff <= S_FIN_WR;
               end
            end
            S_FIN_WR: begin
               a_ff <= a_ff + 1'b1;
               if (int'(d_ff) == MAX_DIMS - 1) begin
                  c_ff <= c_ff + 1'b1;
                  if (int'(c_ff) == MAX_CENTERS - 1) begin
                     state_ff <= S_FIN_EMIT;
                  end else begin
                     state_ff <= S_FIN_CRD;
                  end
               end else begin
                  d_ff     <= d_ff + 1'b1;
                  state_ff <= S_FIN_SRD;
               end
            end
            S_FIN_EMIT: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  total_ff     <= '0;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      p1_first_ff <= d_ff == '0;
      p1_last_ff  <= d_ff == n_dims - 1'b1;
      p1_end_ff   <= (d_ff == n_dims - 1'b1) && (c_ff == n_centers - 1'b1);
      p1_c_ff     <= c_ff;
      p2_first_ff <= p1_first_ff;
      p2_last_ff  <= p1_last_ff;
      p2_end_ff   <= p1_end_ff;
      p2_c_ff     <= p1_c_ff;
      sq_ff       <= sq_c;
      s_last_ff   <= d_ff == n_dims - 1'b1;
      s_addr_ff   <= a_ff;

      if (p2_valid_ff) begin
         acc_ff <= acc_sum;
         // strict compare keeps the lower index on a tie
         if (p2_last_ff && (p2_c_ff == '0 || acc_sum < best_dist_ff)) begin
            best_ff      <= KAW'(p2_c_ff);
            best_dist_ff <= acc_sum;
         end
      end

      case (state_ff)
         S_SQRT_LD: begin
            x_ff    <= best_dist_ff;
            rem_ff  <= '0;
            root_ff <= '0;
         end
         S_SQRT: begin
            x_ff <= x_ff << 2;
            if (rem_sh >= trial) begin
               rem_ff  <= rem_sh - trial;
               root_ff <= {root_ff[RB-2:0], 1'b1};
            end else begin
               rem_ff  <= rem_sh;
               root_ff <= {root_ff[RB-2:0], 1'b0};
            end
         end
         S_EMIT_A: begin
            // a result still waiting on the output keeps its fields
            if (out_free) begin
               rsp_kind_ff  <= KIND_ASSIGN;
               rsp_class_ff <= 4'(best_ff);
               rsp_root_ff  <= root_sat;
               rsp_total_ff <= '0;
            end
         end
         S_CNT_RD: base_ff <= CAW'(int'(best_ff) * MAX_DIMS);
         S_FIN_CWT: begin
            cnt_ff    <= cnt_rdata;
            active_ff <= (c_ff < n_centers) && (cnt_rdata != '0);
         end
         S_FIN_SWT: begin
            wr_center_ff <= active_ff && (d_ff < n_dims);
            quot_ff      <= div_sat ? '1 : '0;
            div_rem_ff   <= DVW'(sum_rdata);
            div_dv_ff    <= DVW'(cnt_ff) << (QUOT_BITS - 1);
         end
         S_FIN_DIV: begin
            div_dv_ff <= div_dv_ff >> 1;
            if (div_rem_ff >= div_dv_ff) begin
               div_rem_ff <= div_rem_ff - div_dv_ff;
               quot_ff    <= {quot_ff[QUOT_BITS-2:0], 1'b1};
            end else begin
               quot_ff <= {quot_ff[QUOT_BITS-2:0], 1'b0};
            end
         end
         S_FIN_EMIT: begin
            if (out_free) begin
               rsp_kind_ff  <= KIND_TOTAL;
               rsp_class_ff <= '0;
               rsp_root_ff  <= '0;
               rsp_total_ff <= total_ff;
            end
         end
         default: ;
      endcase
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.result_kind    = rsp_kind_ff;
   assign rsp.nearest_class  = rsp_class_ff;
   assign rsp.root_distance  = rsp_root_ff;
   assign rsp.total_distance = rsp_total_ff;

   `KMAU_ASSERT_IMPLY(a_rsp_source, clock, reset, $rose(rsp_valid_ff),
      $past(state_ff) == S_EMIT_A || $past(state_ff) == S_FIN_EMIT)
   `KMAU_ASSERT_IMPLY(a_best_in_range, clock, reset, state_ff == S_EMIT_A,
      best_ff < n_centers)
   `KMAU_ASSERT(a_total_cleared, clock, reset,
      (state_ff == S_FIN_EMIT && out_free) |=> (total_ff == '0 && state_ff == S_IDLE))
endmodule

// ----- src/kmeans_assign_update_unit.sv -----
// K-means assign/update unit (one Lloyd iteration, Q0.16 elements).
// req: command/center_slot/dim_slot/elem_value items; load, sample, finish.
// rsp: result_kind/nearest_class/root_distance/total_distance.
// csr: writes centers_in_use (index 0) and dims_in_use (index 1), always ready.
// Items pass a two-entry queue to the sequencer, which works on one at a time.
// Load or non-final sample: taken and written to memory by the idle sequencer.
// Final sample of a vector: distance search (one multiply-accumulate per cycle over
// the center memory), then a load step and (32 + log2(MAX_DIMS))/2 rounded up
// root steps, then the class-sum update; result after the search and root steps.
// Finish: a sweep over all MAX_CENTERS*MAX_DIMS sum entries; a count read per center
// row, then per entry a read, a division when due (one quotient bit per cycle), a write.
// After reset a clearing pass over all MAX_CENTERS*MAX_DIMS entries zeroes sums and
// counts; req.ready is low meanwhile. Register writes are taken throughout.
// A result waits in the output register while rsp.ready is low; the sequencer
// stalls only when a second result is ready, the queue takes items until full.
// Depends on kmau_pkg, kmau_if, kmau_front, kmau_back.
module kmeans_assign_update_unit #(
   parameter int MAX_CENTERS = kmau_pkg::DEF_MAX_CENTERS,
   parameter int MAX_DIMS = kmau_pkg::DEF_MAX_DIMS,
   parameter int COUNT_BITS = kmau_pkg::DEF_COUNT_BITS
) (
   input logic        clock,
   input logic        reset,
   kmau_req_if.sink   req,
   kmau_rsp_if.source rsp,
   kmau_csr_if.sink   csr
);
   import kmau_pkg::*;

   localparam int NCW = $clog2(MAX_CENTERS + 1);
   localparam int NDW = $clog2(MAX_DIMS + 1);

   logic [NCW-1:0] n_centers;
   logic [NDW-1:0] n_dims;
   work_type       q_head;
   logic           q_valid;
   logic           q_pop;
   logic           clearing;

   kmau_front #(.MAX_CENTERS(MAX_CENTERS), .MAX_DIMS(MAX_DIMS)) u_front (
      .clock(clock), .reset(reset), .req(req), .csr(csr), .clearing(clearing),
      .n_centers(n_centers), .n_dims(n_dims), .q_head(q_head), .q_valid(q_valid),
      .q_pop(q_pop));

   kmau_back #(.MAX_CENTERS(MAX_CENTERS), .MAX_DIMS(MAX_DIMS),
               .COUNT_BITS(COUNT_BITS)) u_back (
      .clock(clock), .reset(reset), .n_centers(n_centers), .n_dims(n_dims),
      .q_head(q_head), .q_valid(q_valid), .q_pop(q_pop), .clearing(clearing),
      .rsp(rsp));
endmodule

// ----- bench/testbench.sv -----
// Self-checking bench for kmeans_assign_update_unit: directed rows, then random rounds.
// Depends on kmau_pkg and the kmau_req_if / kmau_rsp_if / kmau_csr_if interfaces.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import kmau_pkg::*;

   localparam int NCENT = DEF_MAX_CENTERS;
   localparam int NDIM = DEF_MAX_DIMS;
   localparam int WATCHDOG_LIMIT = 200000;
   // covers the class-sum update that runs on after an assignment result
   localparam int SETTLE_CYCLES = 200;
   localparam int ITEM_TARGET = 1150;
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   typedef struct packed {
      logic        kind;
      logic [3:0]  cls;
      logic [19:0] root;
      logic [47:0] tot;
   } result_type;

   typedef struct packed {
      bit          cfg;
      logic [1:0]  code;
      logic [3:0]  cs;
      logic [6:0]  ds;
      logic [15:0] v;
      bit          typed;
      result_type  res;
   } row_type;

   logic clock;
   logic reset;

   kmau_req_if req_if();
   kmau_rsp_if rsp_if();
   kmau_csr_if csr_if();

   kmeans_assign_update_unit u_dut (
      .clock(clock),
      .reset(reset),
      .req(req_if),
      .rsp(rsp_if),
      .csr(csr_if)
   );

   // model state of the block
   logic [15:0] center_mem [NCENT][NDIM];
   logic [15:0] vec_buf [NDIM];
   logic [39:0] sum_mem [NCENT][NDIM];
   logic [23:0] hit_count [NCENT];
   logic [47:0] dist_total;
   logic [4:0]  centers_reg;
   logic [7:0]  dims_reg;
   bit          center_written [NCENT][NDIM];
   bit          buf_written [NDIM];

   result_type expected_q[$];
   int errors = 0;
   int items_sent = 0;
   int vectors_sent = 0;
   int finishes_sent = 0;
   int cfg_writes = 0;
   int results_seen = 0;
   int idle_mode = 0;
   int watchdog = 0;

   row_type dir_rows[] = '{
      '{1'b0, CMD_FINISH, 4'd0, 7'd0, 16'h0000, 1'b1, '{KIND_TOTAL, 4'd0, 20'd0, 48'd0}},
      '{1'b1, CSR_CENTERS, 4'd0, 7'd0, 16'd2, 1'b0, '0},
      '{1'b1, CSR_DIMS, 4'd0, 7'd0, 16'd2, 1'b0, '0},
      '{1'b0, CMD_LOAD, 4'd0, 7'd0, 16'h0000, 1'b0, '0},
      '{1'b0, CMD_LOAD, 4'd0, 7'd1, 16'h0000, 1'b0, '0},
      '{1'b0, CMD_LOAD, 4'd1, 7'd0, 16'hFFFF, 1'b0, '0},
      '{1'b0, CMD_LOAD, 4'd1, 7'd1, 16'hFFFF, 1'b0, '0},
      '{1'b0, CMD_SAMPLE, 4'd0, 7'd0, 16'hFFFF, 1'b0, '0},
      '{1'b0, CMD_SAMPLE, 4'd0, 7'd1, 16'hFFFF, 1'b1, '{KIND_ASSIGN, 4'd1, 20'd0, 48'd0}},
      '{1'b0, CMD_SAMPLE, 4'd0, 7'd0, 16'h0000, 1'b0, '0},
      '{1'b0, CMD_SAMPLE, 4'd0, 7'd1, 16'h0000, 1'b1, '{KIND_ASSIGN, 4'd0, 20'd0, 48'd0}},
      // equal distance to both centers: lower index wins
      '{1'b0, CMD_SAMPLE, 4'd0, 7'd0, 16'hFFFF, 1'b0, '0},
      '{1'b0, CMD_SAMPLE, 4'd0, 7'd1, 16'h0000, 1'b1,
        '{KIND_ASSIGN, 4'd0, 20'd65535, 48'd0}},
      '{1'b0, CMD_UNUSED, 4'd15, 7'd127, 16'hFFFF, 1'b0, '0},
      '{1'b0, CMD_LOAD, 4'd15, 7'd127, 16'h1234, 1'b0, '0},
      '{1'b0, CMD_LOAD, 4'd15, 7'd127, 16'hFFFF, 1'b0, '0},
      '{1'b0, CMD_FINISH, 4'd0, 7'd0, 16'h0000, 1'b1,
        '{KIND_TOTAL, 4'd0, 20'd0, 48'd65535}},
      '{1'b0, CMD_SAMPLE, 4'd0, 7'd0, 16'h1234, 1'b0, '0},
      '{1'b0, CMD_SAMPLE, 4'd0, 7'd1, 16'h4321, 1'b0, '0},
      '{1'b0, CMD_FINISH, 4'd0, 7'd0, 16'h0000, 1'b0, '0},
      '{1'b1, CSR_CENTERS, 4'd0, 7'd0, 16'd1, 1'b0, '0},
      '{1'b1, CSR_DIMS, 4'd0, 7'd0, 16'd1, 1'b0, '0},
      '{1'b0, CMD_SAMPLE, 4'd0, 7'd0, 16'hFFFF, 1'b0, '0},
      '{1'b0, CMD_FINISH, 4'd0, 7'd0, 16'h0000, 1'b0, '0}
   };

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int clamp_reg(input int v, input int maxv);
      if (v == 0) return 1;
      return (v > maxv) ? maxv : v;
   endfunction

   function automatic logic [63:0] floor_root(input logic [63:0] x);
      logic [63:0] r, b, rem;
      r = 0;
      rem = x;
      b = 64'h1 << 62;
      while (b > rem) b = b >> 2;
      while (b != 0) begin
         if (rem >= r + b) begin
            rem = rem - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // buffer entries that a final element at ds would read are all defined
   function automatic bit vector_complete(input int ds);
      int nd;
      nd = clamp_reg(dims_reg, NDIM);
      for (int d = 0; d < nd; d++)
         if (d != ds && !buf_written[d]) return 0;
      return 1;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
      errors++;
   endtask

   // updates the model with one accepted item, queues the result it causes
   task automatic predict_item(input logic [1:0] cmd, input logic [3:0] cs,
                               input logic [6:0] ds, input logic [15:0] v,
                               input bit typed, input result_type typed_res);
      int nc, nd, best;
      logic [63:0] sq_dist, best_dist, diff, root, q, s;
      result_type res;
      nc = clamp_reg(centers_reg, NCENT);
      nd = clamp_reg(dims_reg, NDIM);
      res = '0;
      best = 0;
      best_dist = 0;
      case (cmd)
         CMD_LOAD: begin
            center_mem[cs][ds] = v;
            center_written[cs][ds] = 1;
            return;
         end
         CMD_SAMPLE: begin
            vec_buf[ds] = v;
            buf_written[ds] = 1;
            if (ds != nd - 1) return;
            for (int c = 0; c < nc; c++) begin
               sq_dist = 0;
               for (int d = 0; d < nd; d++) begin
                  diff = (vec_buf[d] > center_mem[c][d]) ? vec_buf[d] - center_mem[c][d]
                                                        : center_mem[c][d] - vec_buf[d];
                  sq_dist = sq_dist + diff * diff;
               end
               if (c == 0 || sq_dist < best_dist) begin
                  best = c;
                  best_dist = sq_dist;
               end
            end
            root = floor_root(best_dist);
            if (root > 64'hFFFFF) root = 64'hFFFFF;
            if ({16'd0, dist_total} + root > 64'hFFFF_FFFF_FFFF) dist_total = '1;
            else dist_total = dist_total + root;
            if (hit_count[best] != '1) hit_count[best] = hit_count[best] + 1;
            for (int d = 0; d < nd; d++) begin
               s = {24'd0, sum_mem[best][d]} + vec_buf[d];
               sum_mem[best][d] = (s > 64'hFF_FFFF_FFFF) ? '1 : s[39:0];
            end
            res.kind = KIND_ASSIGN;
            res.cls = best[3:0];
            res.root = root[19:0];
            vectors_sent++;
         end
         CMD_FINISH: begin
            for (int c = 0; c < nc; c++) begin
               if (hit_count[c] == 0) continue;
               for (int d = 0; d < nd; d++) begin
                  q = sum_mem[c][d] / hit_count[c];
                  center_mem[c][d] = (q > 64'hFFFF) ? 16'hFFFF : q[15:0];
               end
            end
            res.kind = KIND_TOTAL;
            res.tot = dist_total;
            for (int c = 0; c < NCENT; c++) begin
               hit_count[c] = 0;
               for (int d = 0; d < NDIM; d++) sum_mem[c][d] = 0;
            end
            dist_total = 0;
            finishes_sent++;
         end
         default: return;
      endcase
      expected_q.push_back(typed ? typed_res : res);
   endtask

   task automatic send_item(input logic [1:0] cmd, input logic [3:0] cs, input logic [6:0] ds,
                            input logic [15:0] v, input bit typed,
                            input result_type typed_res);
      int gap_pct;
      idle_mode = (items_sent < 400) ? 0 : (items_sent < 800) ? 1 : 2;
      gap_pct = (idle_mode == 0) ? 26 : (idle_mode == 1) ? 61 : 0;
      if ($urandom_range(99) < gap_pct) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.command <= cmd;
      req_if.center_slot <= cs;
      req_if.dim_slot <= ds;
      req_if.elem_value <= v;
      do @(posedge clock); while (!req_if.ready);
      items_sent++;
      predict_item(cmd, cs, ds, v, typed, typed_res);
   endtask

   task automatic drain_results();
      req_if.valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data <= data;
      do @(posedge clock); while (!csr_if.ready);
      csr_if.valid <= 1'b0;
      if (idx == CSR_CENTERS) centers_reg = data[4:0];
      else dims_reg = data;
      cfg_writes++;
   endtask

   task automatic load_missing_centers();
      int nc, nd;
      nc = clamp_reg(centers_reg, NCENT);
      nd = clamp_reg(dims_reg, NDIM);
      for (int c = 0; c < nc; c++)
         for (int d = 0; d < nd; d++)
            if (!center_written[c][d])
               send_item(CMD_LOAD, c[3:0], d[6:0], 16'($urandom), 0, '0);
   endtask

   task automatic send_noise();
      logic [6:0] ds;
      case ($urandom_range(2))
         0: send_item(CMD_UNUSED, 4'($urandom), 7'($urandom), 16'($urandom), 0, '0);
         1: send_item(CMD_LOAD, 4'($urandom), 7'($urandom), 16'($urandom), 0, '0);
         default: begin
            ds = 7'($urandom);
            if (vector_complete(ds))
               send_item(CMD_SAMPLE, 4'($urandom), ds, 16'($urandom), 0, '0);
         end
      endcase
   endtask

   function automatic logic [15:0] pick_value();
      case ($urandom_range(9))
         0: return 16'h0000;
         1: return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   // result side: compare, drive ready, watchdog
   always @(posedge clock) begin
      result_type want;
      if (rsp_if.valid && rsp_if.ready) begin
         results_seen++;
         if (expected_q.size() == 0) begin
            report_mismatch("unexpected result kind", rsp_if.result_kind, 0);
         end else begin
            want = expected_q.pop_front();
            if (rsp_if.result_kind !== want.kind)
               report_mismatch("result_kind", rsp_if.result_kind, want.kind);
            if (rsp_if.nearest_class !== want.cls)
               report_mismatch("nearest_class", rsp_if.nearest_class, want.cls);
            if (rsp_if.root_distance !== want.root)
               report_mismatch("root_distance", rsp_if.root_distance, want.root);
            if (rsp_if.total_distance !== want.tot)
               report_mismatch("total_distance", rsp_if.total_distance, want.tot);
         end
      end
      case (idle_mode)
         0: rsp_if.ready <= ($urandom_range(99) >= 61);
         1: rsp_if.ready <= ($urandom_range(99) >= 26);
         default: rsp_if.ready <= 1'b1;
      endcase
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (csr_if.valid && csr_if.ready))
         watchdog <= 0;
      else
         watchdog <= watchdog + 1;
      if (watchdog >= WATCHDOG_LIMIT) begin
         $display("Timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      int nvec, nd, round;
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.command = CMD_LOAD;
      req_if.center_slot = '0;
      req_if.dim_slot = '0;
      req_if.elem_value = '0;
      csr_if.valid = 1'b0;
      csr_if.index = CSR_CENTERS;
      csr_if.data = '0;
      centers_reg = RST_CENTERS;
      dims_reg = RST_DIMS;
      dist_total = 0;
      for (int c = 0; c < NCENT; c++) begin
         hit_count[c] = 0;
         for (int d = 0; d < NDIM; d++) begin
            center_mem[c][d] = 0;
            sum_mem[c][d] = 0;
            center_written[c][d] = 0;
         end
      end
      for (int d = 0; d < NDIM; d++) begin
         vec_buf[d] = 0;
         buf_written[d] = 0;
      end
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[i]) begin
         if (dir_rows[i].cfg) write_reg(dir_rows[i].code, dir_rows[i].v[7:0]);
         else send_item(dir_rows[i].code, dir_rows[i].cs, dir_rows[i].ds, dir_rows[i].v,
                        dir_rows[i].typed, dir_rows[i].res);
      end

      round = 0;
      while (items_sent < ITEM_TARGET) begin
         case ($urandom_range(9))
            0: begin
               write_reg(CSR_CENTERS, $urandom_range(1) ? 8'd16 : 8'd31);
               write_reg(CSR_DIMS, 8'($urandom_range(1, 2)));
            end
            1: begin
               write_reg(CSR_DIMS, $urandom_range(1) ? 8'd128 : 8'd255);
               write_reg(CSR_CENTERS, 8'($urandom_range(1)));
            end
            2: begin
               write_reg(CSR_CENTERS, 8'($urandom_range(1)));
               write_reg(CSR_DIMS, 8'($urandom_range(1)));
            end
            default: begin
               write_reg(CSR_CENTERS, 8'($urandom_range(1, 4)));
               write_reg(CSR_DIMS, 8'($urandom_range(1, 8)));
            end
         endcase
         load_missing_centers();
         nd = clamp_reg(dims_reg, NDIM);
         if ($urandom_range(3) == 0)
            repeat ($urandom_range(1, 4))
               send_item(CMD_LOAD, 4'($urandom_range(clamp_reg(centers_reg, NCENT) - 1)),
                         7'($urandom_range(nd - 1)), pick_value(), 0, '0);
         nvec = (nd > 16) ? $urandom_range(1, 2) : $urandom_range(2, 8);
         for (int n = 0; n < nvec; n++) begin
            for (int d = 0; d < nd; d++) begin
               if ($urandom_range(99) < 8) send_noise();
               send_item(CMD_SAMPLE, 4'($urandom), d[6:0], pick_value(), 0, '0);
            end
         end
         if (round == 3) drain_results();
         if ($urandom_range(4) != 0) send_item(CMD_FINISH, 4'($urandom), 7'($urandom),
                                               16'($urandom), 0, '0);
         round++;
      end
      send_item(CMD_FINISH, 4'd0, 7'd0, 16'd0, 0, '0);
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Covered %0d items: %0d vectors, %0d finishes, %0d register writes, %0d results",
               items_sent, vectors_sent, finishes_sent, cfg_writes, results_seen);
      if (errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("%0d mismatches", errors);
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end
endmodule

// ----- filelist.f -----
+incdir+src
src/kmau_pkg.sv
src/kmau_if.sv
src/kmau_ram.sv
src/kmau_front.sv
src/kmau_back.sv
src/kmeans_assign_update_unit.sv
bench/testbench.sv
